[rtl/smwf_pkg.sv]
// ----------------------------------------------------------------------------
// smwf_pkg
// Shared types and constants of the spanning maze wall filter: words on both
// channels, the job word between front and back, status and op codes.
// ----------------------------------------------------------------------------
package smwf_pkg;

  // default cell capacity of the disjoint-set table
  localparam int MAX_CELLS_DEF = 1024;

  // field widths
  localparam int CELL_W   = 10;
  localparam int DIM_W    = 11;
  localparam int RANK_W   = 4;
  localparam int BLK_W    = 11;
  localparam int OPN_W    = 10;
  localparam int STATUS_W = 2;

  // remainder unit in the front: bits of the cell index retired per cycle
  localparam int DIV_BITS  = 2;
  localparam int DIV_ITERS = CELL_W / DIV_BITS;

  localparam logic [RANK_W-1:0] RANK_MAX    = 4'd15;
  localparam logic [BLK_W-1:0]  BLOCKED_MAX = 11'd2047;
  localparam logic [OPN_W-1:0]  OPENED_MAX  = 10'd1023;
  localparam logic [DIM_W-1:0]  GRID_RESET  = 11'd32;

  // input codes
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_WALL  = 1'b1;
  localparam logic DIR_LEFT   = 1'b0;
  localparam logic DIR_BELOW  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OPENED  = 2'd0,
    STATUS_BLOCKED = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_CLEARED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_INVALID = 2'd1,
    OP_WALL    = 2'd2
  } op_t;

  typedef struct packed {
    logic              kind;
    logic [CELL_W-1:0] cell_req;
    logic              direction;
  } smwf_in_t;

  typedef struct packed {
    status_t           status;
    logic [CELL_W-1:0] cell_echo;
    logic              direction_echo;
    logic [BLK_W-1:0]  blocked_count;
    logic [OPN_W-1:0]  opened_count;
  } smwf_out_t;

  // classified work handed from front to back
  typedef struct packed {
    op_t               op;
    logic [CELL_W-1:0] cell_num;
    logic              dir;
    logic [CELL_W-1:0] other;
  } smwf_job_t;

endpackage

[rtl/smwf_ram.sv]
// ----------------------------------------------------------------------------
// smwf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module smwf_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/smwf_queue.sv]
// ----------------------------------------------------------------------------
// smwf_queue
// Two-entry job queue between the classifier front and the union-find back.
// ----------------------------------------------------------------------------
module smwf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  smwf_pkg::smwf_job_t push_job,
  output logic                full,
  input  logic                pop,
  output smwf_pkg::smwf_job_t pop_job,
  output logic                valid
);

  smwf_pkg::smwf_job_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign pop_job = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/smwf_front.sv]
// ----------------------------------------------------------------------------
// smwf_front
// Accepts input words, checks the wall against the grid and works out the
// neighbour cell; a left wall runs a two-bit-per-cycle remainder unit to
// find the first column.
// ----------------------------------------------------------------------------
module smwf_front #(
  parameter int MAX_CELLS = smwf_pkg::MAX_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smwf_pkg::smwf_in_t              in_data,
  input  logic                            hold,
  input  logic [smwf_pkg::DIM_W-1:0]      grid_width,
  input  logic [smwf_pkg::DIM_W-1:0]      grid_height,
  output logic                            push,
  output smwf_pkg::smwf_job_t             job,
  input  logic                            full
);

  localparam int IW = $clog2(smwf_pkg::DIV_ITERS);
  localparam int PW = 2 * smwf_pkg::DIM_W;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t                         state;
  logic [smwf_pkg::DIM_W-1:0]      rem;
  logic [smwf_pkg::CELL_W-1:0]     quo;
  logic [IW-1:0]                   iter;

  logic [PW-1:0]                   cells;
  logic                            in_range;
  logic                            row_ok;
  logic                            accept;
  logic [smwf_pkg::DIM_W-1:0]      rem_next;

  assign in_ready = (state == F_IDLE) && !hold;
  assign accept   = in_valid && in_ready;
  assign push     = (state == F_PUSH) && !full;

  // range checks on the incoming word
  always_comb begin
    cells    = grid_width * grid_height;
    in_range = (grid_width != '0) && (PW'(in_data.cell_req) < cells) &&
               (32'(in_data.cell_req) < 32'(MAX_CELLS));
    row_ok   = ({1'b0, in_data.cell_req} >= grid_width);
  end

  // restoring remainder, two quotient bits per cycle
  always_comb begin
    logic [smwf_pkg::DIM_W:0]   s;
    logic [smwf_pkg::DIM_W-1:0] r;
    r = rem;
    for (int k = 0; k < smwf_pkg::DIV_BITS; k++) begin
      s = {r, quo[smwf_pkg::CELL_W-1-k]};
      if (s >= {1'b0, grid_width}) begin
        s = s - {1'b0, grid_width};
      end
      r = s[smwf_pkg::DIM_W-1:0];
    end
    rem_next = r;
  end

  // sequencer and job register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            job.cell_num <= in_data.cell_req;
            job.dir      <= in_data.direction;
            if (in_data.kind == smwf_pkg::KIND_START) begin
              job.op    <= smwf_pkg::OP_CLEAR;
              job.other <= '0;
              state     <= F_PUSH;
            end else if (!in_range) begin
              job.op    <= smwf_pkg::OP_INVALID;
              job.other <= '0;
              state     <= F_PUSH;
            end else if (in_data.direction == smwf_pkg::DIR_BELOW) begin
              job.op    <= row_ok ? smwf_pkg::OP_WALL : smwf_pkg::OP_INVALID;
              job.other <= in_data.cell_req - grid_width[smwf_pkg::CELL_W-1:0];
              state     <= F_PUSH;
            end else begin
              job.op    <= smwf_pkg::OP_INVALID;
              job.other <= in_data.cell_req - smwf_pkg::CELL_W'(1);
              rem       <= '0;
              quo       <= in_data.cell_req;
              iter      <= '0;
              state     <= F_DIV;
            end
          end
        end
        F_DIV: begin
          rem  <= rem_next;
          quo  <= quo << smwf_pkg::DIV_BITS;
          iter <= iter + IW'(1);
          if (iter == IW'(smwf_pkg::DIV_ITERS - 1)) begin
            // first column leaves no neighbour to the left
            job.op <= (rem_next != '0) ? smwf_pkg::OP_WALL : smwf_pkg::OP_INVALID;
            state  <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/smwf_back.sv]
// ----------------------------------------------------------------------------
// smwf_back
// Runs the jobs: clearing sweeps of the disjoint-set table, the two root
// walks, the union by rank, the counters and the output register.
// ----------------------------------------------------------------------------
module smwf_back #(
  parameter int MAX_CELLS = smwf_pkg::MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  smwf_pkg::smwf_job_t  job,
  output logic                 pop,
  output logic                 init_busy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smwf_pkg::smwf_out_t  out_data
);

  localparam int CW = $clog2(MAX_CELLS);
  localparam int RW = smwf_pkg::RANK_W;
  localparam int MW = CW + RW;
  localparam int XW = CW + smwf_pkg::CELL_W;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_FIND_A,
    B_FIND_B,
    B_JOIN,
    B_BUMP,
    B_RESULT
  } bstate_t;

  bstate_t             state;
  smwf_pkg::smwf_job_t cur_job;
  smwf_pkg::status_t   status;
  logic [CW-1:0]       sweep;
  logic [CW-1:0]       cur;
  logic [CW-1:0]       root_a;
  logic [CW-1:0]       root_b;
  logic [RW-1:0]       rank_a;
  logic [RW-1:0]       rank_b;
  logic [smwf_pkg::BLK_W-1:0] blocked;
  logic [smwf_pkg::OPN_W-1:0] opened;

  logic          we;
  logic [CW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [CW-1:0] raddr;
  logic [MW-1:0] rdata;
  logic [CW-1:0] rd_par;
  logic [RW-1:0] rd_rank;
  logic          at_root;
  logic          sweep_last;
  logic          slot_free;
  logic          load_out;
  logic [XW-1:0] ext_head;
  logic [XW-1:0] ext_other;
  logic [CW-1:0] head_idx;
  logic [CW-1:0] other_idx;

  smwf_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_CELLS)
  ) u_sets (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cell numbers resized to the table index
  assign ext_head  = {{CW{1'b0}}, job.cell_num};
  assign ext_other = {{CW{1'b0}}, cur_job.other};
  assign head_idx  = ext_head[CW-1:0];
  assign other_idx = ext_other[CW-1:0];

  assign rd_par     = rdata[MW-1:RW];
  assign rd_rank    = rdata[RW-1:0];
  assign at_root    = (rd_par == cur);
  assign sweep_last = (sweep == CW'(MAX_CELLS - 1));
  assign slot_free  = !out_valid || out_ready;
  assign load_out   = (state == B_RESULT) && slot_free;
  assign pop        = (state == B_IDLE) && job_valid;
  assign init_busy  = (state == B_INIT);

  // table read address: next link of the walk
  always_comb begin
    case (state)
      B_IDLE:   raddr = head_idx;
      B_FIND_A: raddr = at_root ? other_idx : rd_par;
      B_FIND_B: raddr = rd_par;
      default:  raddr = cur;
    endcase
  end

  // table writes: clearing sweep and union by rank
  always_comb begin
    we    = 1'b0;
    waddr = sweep;
    wdata = {sweep, {RW{1'b0}}};
    case (state)
      B_INIT, B_CLEAR: begin
        we = 1'b1;
      end
      B_JOIN: begin
        if (root_a != root_b) begin
          we = 1'b1;
          if (rank_a < rank_b) begin
            waddr = root_a;
            wdata = {root_b, rank_a};
          end else begin
            waddr = root_b;
            wdata = {root_a, rank_b};
          end
        end
      end
      B_BUMP: begin
        we    = 1'b1;
        waddr = root_a;
        wdata = {root_a, rank_a + RW'(1)};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      blocked   <= '0;
      opened    <= '0;
      out_valid <= 1'b0;
    end else begin
      // result word held until taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_INIT: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= B_IDLE;
          end else begin
            sweep <= sweep + CW'(1);
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cur_job <= job;
            case (job.op)
              smwf_pkg::OP_CLEAR: begin
                sweep <= '0;
                state <= B_CLEAR;
              end
              smwf_pkg::OP_WALL: begin
                cur   <= head_idx;
                state <= B_FIND_A;
              end
              default: begin
                status <= smwf_pkg::STATUS_INVALID;
                state  <= B_RESULT;
              end
            endcase
          end
        end
        B_CLEAR: begin
          if (sweep_last) begin
            sweep   <= '0;
            blocked <= '0;
            opened  <= '0;
            status  <= smwf_pkg::STATUS_CLEARED;
            state   <= B_RESULT;
          end else begin
            sweep <= sweep + CW'(1);
          end
        end
        B_FIND_A: begin
          if (at_root) begin
            root_a <= cur;
            rank_a <= rd_rank;
            cur    <= other_idx;
            state  <= B_FIND_B;
          end else begin
            cur <= rd_par;
          end
        end
        B_FIND_B: begin
          if (at_root) begin
            root_b <= cur;
            rank_b <= rd_rank;
            state  <= B_JOIN;
          end else begin
            cur <= rd_par;
          end
        end
        B_JOIN: begin
          if (root_a == root_b) begin
            status <= smwf_pkg::STATUS_BLOCKED;
            if (blocked != smwf_pkg::BLOCKED_MAX) begin
              blocked <= blocked + smwf_pkg::BLK_W'(1);
            end
            state <= B_RESULT;
          end else begin
            status <= smwf_pkg::STATUS_OPENED;
            if (opened != smwf_pkg::OPENED_MAX) begin
              opened <= opened + smwf_pkg::OPN_W'(1);
            end
            // equal ranks: the surviving root grows, held at the top value
            if (rank_a == rank_b && rank_a != smwf_pkg::RANK_MAX) begin
              state <= B_BUMP;
            end else begin
              state <= B_RESULT;
            end
          end
        end
        B_BUMP: begin
          state <= B_RESULT;
        end
        B_RESULT: begin
          if (slot_free) begin
            out_data.status         <= status;
            out_data.cell_echo      <= cur_job.cell_num;
            out_data.direction_echo <= cur_job.dir;
            out_data.blocked_count  <= blocked;
            out_data.opened_count   <= opened;
            state                   <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/spanning_maze_wall_filter.sv]
// ----------------------------------------------------------------------------
// spanning_maze_wall_filter
// Kruskal maze wall filter over a row-major grid with a union-find table.
// ----------------------------------------------------------------------------
// Each input word either starts a new maze (every cell its own set, counters
// cleared) or offers one wall: the cell and its left or lower neighbour. A
// wall between two sets is opened and the sets joined, a wall inside one set
// stays blocked, a wall off the grid is reported invalid; exactly one result
// word comes out per input word, in order. A wall's walk in the back end
// makes one table read per link of each cell's parent chain (on the single
// read port of the set table), plus the rank bump state when equal ranks
// grow; the front's remainder unit runs on a left wall but overlaps the
// previous wall's walk through the two-word job queue. A start word sweeps
// the whole table, one entry a cycle. After reset the same sweep runs with
// in_ready low; register writes are taken throughout.
module spanning_maze_wall_filter #(
  parameter int MAX_CELLS = smwf_pkg::MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // wall words in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smwf_pkg::smwf_in_t   in_data,
  // result words out
  output logic                 out_valid,
  input  logic                 out_ready,
  output smwf_pkg::smwf_out_t  out_data
);

  logic [smwf_pkg::DIM_W-1:0] grid_width;
  logic [smwf_pkg::DIM_W-1:0] grid_height;
  logic                       cfg_write;

  smwf_pkg::smwf_job_t front_job;
  smwf_pkg::smwf_job_t head_job;
  logic                front_push;
  logic                queue_full;
  logic                queue_valid;
  logic                back_pop;
  logic                init_busy;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == smwf_pkg::REG_GRID_HEIGHT) begin
      prdata = {{(32 - smwf_pkg::DIM_W){1'b0}}, grid_height};
    end else begin
      prdata = {{(32 - smwf_pkg::DIM_W){1'b0}}, grid_width};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= smwf_pkg::GRID_RESET;
      grid_height <= smwf_pkg::GRID_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == smwf_pkg::REG_GRID_WIDTH) begin
        grid_width <= pwdata[smwf_pkg::DIM_W-1:0];
      end else begin
        grid_height <= pwdata[smwf_pkg::DIM_W-1:0];
      end
    end
  end

  // classifier front
  smwf_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .hold        (init_busy),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .push        (front_push),
    .job         (front_job),
    .full        (queue_full)
  );

  // job queue
  smwf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_job (front_job),
    .full     (queue_full),
    .pop      (back_pop),
    .pop_job  (head_job),
    .valid    (queue_valid)
  );

  // union-find back
  smwf_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (head_job),
    .pop       (back_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a fresh maze reports empty counters
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == smwf_pkg::STATUS_CLEARED |->
      out_data.blocked_count == '0 && out_data.opened_count == '0)
    else $error("cleared result with non-zero counters");

  // opened walls form a forest, so never reach the cell capacity
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.opened_count) < 32'(MAX_CELLS))
    else $error("more walls opened than a spanning forest allows");

  // cell zero has no left neighbour
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != smwf_pkg::STATUS_CLEARED &&
      out_data.direction_echo == smwf_pkg::DIR_LEFT && out_data.cell_echo == '0 |->
      out_data.status == smwf_pkg::STATUS_INVALID)
    else $error("left wall of cell zero not flagged invalid");

  // no word is taken while the table is being cleared after reset
  assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !in_ready && !back_pop)
    else $error("word taken during the reset sweep");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spanning maze wall filter. A union-find
// predictor in the scoreboard computes the verdict word for every wall and
// start word the block accepts; result words are matched in order, field by
// field. Directed walls hit grid edges, zero and oversized grids, and resize
// without a start. A run fills an 8x8 maze to its spanning tree and then
// offers walls that all stay blocked. Random phases follow, mostly on small
// grids, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CELL_CAP = smwf_pkg::MAX_CELLS_DEF;

  // union-find predictor and store of awaited verdict words
  class maze_scoreboard;
    logic [smwf_pkg::CELL_W-1:0] parent_of [CELL_CAP];
    logic [smwf_pkg::RANK_W-1:0] set_rank [CELL_CAP];
    logic [smwf_pkg::BLK_W-1:0]  blocked_total;
    logic [smwf_pkg::OPN_W-1:0]  opened_total;
    logic [smwf_pkg::DIM_W-1:0]  grid_w;
    logic [smwf_pkg::DIM_W-1:0]  grid_h;
    smwf_pkg::smwf_out_t         wall_verdicts[$];
    int                          mismatches;

    function new();
      grid_w = smwf_pkg::GRID_RESET;
      grid_h = smwf_pkg::GRID_RESET;
      mismatches = 0;
      clear_sets();
    endfunction

    function void clear_sets();
      for (int i = 0; i < CELL_CAP; i++) begin
        parent_of[i] = smwf_pkg::CELL_W'(i);
        set_rank[i] = '0;
      end
      blocked_total = '0;
      opened_total = '0;
    endfunction

    function void set_grid(logic idx, logic [smwf_pkg::DIM_W-1:0] value);
      if (idx == smwf_pkg::REG_GRID_WIDTH) grid_w = value;
      else grid_h = value;
    endfunction

    function int unsigned find_root(int unsigned c);
      int unsigned steps;
      steps = 0;
      while (parent_of[c] != c && steps < CELL_CAP) begin
        c = parent_of[c];
        steps++;
      end
      return c;
    endfunction

    function int pending();
      return wall_verdicts.size();
    endfunction

    // work out the verdict for one accepted word and queue it
    function void judge_wall(smwf_pkg::smwf_in_t w);
      smwf_pkg::smwf_out_t r;
      int unsigned         cell_idx, other, limit, ra, rb;
      bit                  ok;
      cell_idx = w.cell_req;
      other = 0;
      r.cell_echo = w.cell_req;
      r.direction_echo = w.direction;
      if (w.kind == smwf_pkg::KIND_START) begin
        clear_sets();
        r.status = smwf_pkg::STATUS_CLEARED;
      end else begin
        limit = int'(grid_w) * int'(grid_h);
        if (limit > CELL_CAP) limit = CELL_CAP;
        ok = (grid_w != 0) && (cell_idx < limit);
        if (ok) begin
          if (w.direction == smwf_pkg::DIR_LEFT) begin
            ok = (cell_idx % grid_w) != 0;
            other = cell_idx - 1;
          end else begin
            ok = cell_idx >= grid_w;
            other = cell_idx - grid_w;
          end
        end
        if (!ok) begin
          r.status = smwf_pkg::STATUS_INVALID;
        end else begin
          ra = find_root(cell_idx);
          rb = find_root(other);
          if (ra == rb) begin
            r.status = smwf_pkg::STATUS_BLOCKED;
            if (blocked_total != smwf_pkg::BLOCKED_MAX) blocked_total++;
          end else begin
            r.status = smwf_pkg::STATUS_OPENED;
            // union by rank, rank holds at its ceiling
            if (set_rank[ra] < set_rank[rb]) begin
              parent_of[ra] = rb[smwf_pkg::CELL_W-1:0];
            end else if (set_rank[ra] > set_rank[rb]) begin
              parent_of[rb] = ra[smwf_pkg::CELL_W-1:0];
            end else begin
              parent_of[rb] = ra[smwf_pkg::CELL_W-1:0];
              if (set_rank[ra] != smwf_pkg::RANK_MAX) set_rank[ra]++;
            end
            if (opened_total != smwf_pkg::OPENED_MAX) opened_total++;
          end
        end
      end
      r.blocked_count = blocked_total;
      r.opened_count = opened_total;
      wall_verdicts = {wall_verdicts, r};
    endfunction

    // compare one result word with the oldest awaited verdict
    function void check_verdict(smwf_pkg::smwf_out_t got);
      smwf_pkg::smwf_out_t exp;
      if (wall_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d cell %0d dir %0d blk %0d opn %0d",
                   got.status, got.cell_echo, got.direction_echo,
                   got.blocked_count, got.opened_count);
        return;
      end
      exp = wall_verdicts.pop_front();
      if (got.status !== exp.status || got.cell_echo !== exp.cell_echo ||
          got.direction_echo !== exp.direction_echo ||
          got.blocked_count !== exp.blocked_count ||
          got.opened_count !== exp.opened_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp status %0d cell %0d dir %0d blk %0d opn %0d,",
                    " got %0d %0d %0d %0d %0d"},
                   exp.status, exp.cell_echo, exp.direction_echo, exp.blocked_count,
                   exp.opened_count, got.status, got.cell_echo, got.direction_echo,
                   got.blocked_count, got.opened_count);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  smwf_pkg::smwf_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  smwf_pkg::smwf_out_t out_data;

  int sender_idle_pct;
  int receiver_stall_pct;

  maze_scoreboard board = new();

  spanning_maze_wall_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) board.check_verdict(out_data);
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic smwf_pkg::smwf_in_t make_word(logic kind, int unsigned cell_idx,
                                                   logic dir);
    smwf_pkg::smwf_in_t w;
    w.kind = kind;
    w.cell_req = cell_idx[smwf_pkg::CELL_W-1:0];
    w.direction = dir;
    return w;
  endfunction

  // present one word, with a random idle gap in front, until accepted
  task automatic send_word(input smwf_pkg::smwf_in_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.judge_wall(w);
  endtask

  task automatic offer_wall(input int unsigned cell_idx, input logic dir);
    send_word(make_word(smwf_pkg::KIND_WALL, cell_idx, dir));
  endtask

  task automatic start_maze(input int unsigned cell_idx, input logic dir);
    send_word(make_word(smwf_pkg::KIND_START, cell_idx, dir));
  endtask

  // stop sending until all verdicts are back, then let the block settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_grid(idx, value[smwf_pkg::DIM_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // only written once every result is back, so nothing is in flight
  task automatic configure_grid(input int unsigned w, input int unsigned h);
    wait_idle(CELL_CAP + 16);
    write_reg(smwf_pkg::REG_GRID_WIDTH, w);
    write_reg(smwf_pkg::REG_GRID_HEIGHT, h);
  endtask

  // mostly a wall with both cells on the grid, random otherwise
  task automatic offer_grid_wall(input int unsigned w, input int unsigned h);
    int unsigned limit, cell_idx;
    logic        dir;
    limit = w * h;
    if (limit > CELL_CAP) limit = CELL_CAP;
    if (w == 0 || limit < 2) begin
      offer_wall($urandom_range(CELL_CAP - 1), 1'($urandom_range(1)));
    end else begin
      cell_idx = $urandom_range(limit - 1);
      dir = 1'($urandom_range(1));
      if (dir == smwf_pkg::DIR_LEFT && cell_idx % w == 0) dir = smwf_pkg::DIR_BELOW;
      else if (dir == smwf_pkg::DIR_BELOW && cell_idx < w) dir = smwf_pkg::DIR_LEFT;
      offer_wall(cell_idx, dir);
    end
  endtask

  task automatic random_phase(input int n_words);
    int unsigned w, h;
    int          pick;
    if ($urandom_range(9) == 0) begin
      w = $urandom_range(2047);
      h = $urandom_range(2047);
    end else begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
    end
    configure_grid(w, h);
    // now and then keep the old sets across the resize
    if ($urandom_range(3) != 0)
      start_maze($urandom_range(CELL_CAP - 1), 1'($urandom_range(1)));
    for (int i = 0; i < n_words; i++) begin
      if (i == n_words / 2) wait_idle(0);
      pick = $urandom_range(99);
      if (pick < 3) start_maze($urandom_range(CELL_CAP - 1), 1'($urandom_range(1)));
      else if (pick < 15) offer_wall($urandom_range(CELL_CAP - 1), 1'($urandom_range(1)));
      else offer_grid_wall(w, h);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed walls on the reset grid of 32x32
    start_maze(1023, smwf_pkg::DIR_BELOW);
    offer_wall(0, smwf_pkg::DIR_LEFT);
    offer_wall(0, smwf_pkg::DIR_BELOW);
    offer_wall(1, smwf_pkg::DIR_LEFT);
    offer_wall(1, smwf_pkg::DIR_LEFT);
    offer_wall(33, smwf_pkg::DIR_BELOW);
    offer_wall(32, smwf_pkg::DIR_LEFT);
    offer_wall(32, smwf_pkg::DIR_BELOW);
    offer_wall(33, smwf_pkg::DIR_LEFT);
    offer_wall(1023, smwf_pkg::DIR_BELOW);
    // zero width, then zero height: no cells at all
    configure_grid(0, 5);
    offer_wall(3, smwf_pkg::DIR_BELOW);
    configure_grid(4, 0);
    offer_wall(5, smwf_pkg::DIR_LEFT);
    // resized without a start, sets carried over
    configure_grid(2047, 1);
    offer_wall(1023, smwf_pkg::DIR_LEFT);
    offer_wall(5, smwf_pkg::DIR_BELOW);
    configure_grid(1024, 1024);
    offer_wall(1023, smwf_pkg::DIR_BELOW);
    offer_wall(1000, smwf_pkg::DIR_LEFT);
    configure_grid(1, 1024);
    offer_wall(7, smwf_pkg::DIR_LEFT);
    offer_wall(7, smwf_pkg::DIR_BELOW);
    configure_grid(3, 3);
    offer_wall(9, smwf_pkg::DIR_LEFT);
    offer_wall(8, smwf_pkg::DIR_BELOW);
    start_maze(0, smwf_pkg::DIR_LEFT);

    // full spanning tree on 8x8, then walls that all stay blocked
    configure_grid(8, 8);
    start_maze(512, smwf_pkg::DIR_LEFT);
    for (int y = 0; y < 8; y++)
      for (int x = 1; x < 8; x++) offer_wall(y * 8 + x, smwf_pkg::DIR_LEFT);
    for (int y = 1; y < 8; y++) offer_wall(y * 8, smwf_pkg::DIR_BELOW);
    repeat (100) offer_grid_wall(8, 8);

    // random phases under each idle mix
    for (int p = 0; p < 4; p++) begin
      wait_idle(0);
      case (p)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
        default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
      endcase
      random_phase(45);
      random_phase(45);
    end

    wait_idle(64);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
